/* hw/rtl/hsl2rgb_pkg.sv */
// hsl2rgb_pkg: shared constants, types and the divide-by-65535 helper
// for the hsl to rgb converter; no dependencies
`timescale 1ns / 1ps

package hsl2rgb_pkg;

  // fractions are unsigned, 65535 stands for one
  localparam logic [15:0] FRAC_ONE   = 16'hFFFF;
  localparam logic [15:0] FRAC_THIRD = 16'd21845;
  // 4 * FRAC_ONE, start of the falling hue ramp in units of 6v
  localparam logic [18:0] FALL_BASE  = 19'd262140;
  // 2v < one  <=>  v below this
  localparam logic [15:0] HALF_LIMIT = 16'd32768;
  // 3v < 2 * one  <=>  v below this
  localparam logic [15:0] FALL_LIMIT = 16'd43690;

  localparam int PIPE_STAGES = 6;
  localparam int STG_PROD    = 0;
  localparam int STG_LEVEL   = 1;
  localparam int STG_HMUL    = 2;
  localparam int STG_HMIX    = 3;
  localparam int STG_SMUL    = 4;
  localparam int STG_OUT     = 5;

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } hue_seg_e;

  typedef struct packed {
    logic [PIPE_STAGES-1:0] load;
  } pipe_ctrl_t;

  // floor(x / 65535) by two folding steps and one final correction
  function automatic logic [17:0] div_frac_one(input logic [33:0] x);
    logic [17:0] q0;
    logic [18:0] r0;
    logic [2:0]  q1;
    logic [16:0] r1;
    logic        c;
    q0 = x[33:16];
    r0 = 19'(x[15:0]) + 19'(q0);
    q1 = r0[18:16];
    r1 = 17'(r0[15:0]) + 17'(q1);
    c  = (r1 >= 17'(FRAC_ONE));
    return q0 + 18'(q1) + 18'(c);
  endfunction

endpackage

/* hw/rtl/hsl2rgb_if.sv */
// hsl2rgb_hsl_if and hsl2rgb_rgb_if: valid/ready channels carrying one
// hsl item in and one rgb item out; no dependencies
`timescale 1ns / 1ps

interface hsl2rgb_hsl_if;
  logic        valid;
  logic        ready;
  logic [15:0] hue;
  logic [15:0] saturation;
  logic [15:0] lightness;

  modport source (output valid, output hue, output saturation, output lightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input lightness,
                  output ready);
endinterface

interface hsl2rgb_rgb_if #(
  parameter int OUT_BITS = 8
);
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] red;
  logic [OUT_BITS-1:0] green;
  logic [OUT_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* hw/rtl/hsl_to_rgb_converter.sv */
// hsl_to_rgb_converter: top level, hsl item in, rgb item out
// depends on hsl2rgb_pkg, hsl2rgb_if, hsl2rgb_ctrl, hsl2rgb_levels, hsl2rgb_chan
// Converts one 16-bit hue/saturation/lightness item per clock into red,
// green and blue of OUT_BITS bits each (standard hsl method, fractions in
// units of 1/65535, truncating). The pipeline is six register stages deep,
// and a new item is taken in every cycle in which input ready is high. The
// stages follow the three multiplications (level product, hue ramp product,
// output scale product), each followed by a stage that divides by 65535.
// Every stage holds its item while the output side stalls and bubbles close
// up, so input ready drops only when all six stages are full and the output
// is not being taken. Zero saturation needs no special path and yields grey.
`timescale 1ns / 1ps

module hsl_to_rgb_converter
  import hsl2rgb_pkg::*;
#(
  parameter int OUT_BITS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hsl2rgb_hsl_if.sink   hsl_i,
  hsl2rgb_rgb_if.source rgb_o
);

  pipe_ctrl_t pipe;

  hsl2rgb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (hsl_i.valid),
    .in_ready_o  (hsl_i.ready),
    .out_valid_o (rgb_o.valid),
    .out_ready_i (rgb_o.ready),
    .pipe_o      (pipe)
  );

  logic [15:0] hue_r, hue_g, hue_b;
  logic [15:0] lo, hi, diff;

  hsl2rgb_levels u_levels (
    .clk_i   (clk_i),
    .pipe_i  (pipe),
    .hue_i   (hsl_i.hue),
    .sat_i   (hsl_i.saturation),
    .light_i (hsl_i.lightness),
    .hue_r_o (hue_r),
    .hue_g_o (hue_g),
    .hue_b_o (hue_b),
    .lo_o    (lo),
    .hi_o    (hi),
    .diff_o  (diff)
  );

  logic [OUT_BITS-1:0] red, green, blue;

  hsl2rgb_chan #(.OUT_BITS(OUT_BITS)) u_chan_r (
    .clk_i   (clk_i),
    .pipe_i  (pipe),
    .hue_i   (hue_r),
    .lo_i    (lo),
    .hi_i    (hi),
    .diff_i  (diff),
    .level_o (red)
  );

  hsl2rgb_chan #(.OUT_BITS(OUT_BITS)) u_chan_g (
    .clk_i   (clk_i),
    .pipe_i  (pipe),
    .hue_i   (hue_g),
    .lo_i    (lo),
    .hi_i    (hi),
    .diff_i  (diff),
    .level_o (green)
  );

  hsl2rgb_chan #(.OUT_BITS(OUT_BITS)) u_chan_b (
    .clk_i   (clk_i),
    .pipe_i  (pipe),
    .hue_i   (hue_b),
    .lo_i    (lo),
    .hi_i    (hi),
    .diff_i  (diff),
    .level_o (blue)
  );

  assign rgb_o.red   = red;
  assign rgb_o.green = green;
  assign rgb_o.blue  = blue;

endmodule

/* hw/rtl/hsl2rgb_ctrl.sv */
// hsl2rgb_ctrl: valid bits and per-stage load enables of the pipeline
// depends on hsl2rgb_pkg
`timescale 1ns / 1ps

module hsl2rgb_ctrl
  import hsl2rgb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pipe_ctrl_t pipe_o
);

  localparam int LAST = PIPE_STAGES - 1;

  logic [PIPE_STAGES-1:0] valid_q, valid_d;
  logic [PIPE_STAGES-1:0] rdy;
  logic [PIPE_STAGES-1:0] vin;

  always_comb begin
    rdy[LAST] = !valid_q[LAST] || out_ready_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    vin[0] = in_valid_i;
    for (int k = 1; k < PIPE_STAGES; k++) begin
      vin[k] = valid_q[k-1];
    end
    for (int k = 0; k < PIPE_STAGES; k++) begin
      pipe_o.load[k] = vin[k] && rdy[k];
      valid_d[k]     = rdy[k] ? vin[k] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[LAST];

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[LAST] |-> in_ready_o)
    else $error("input stalled with empty output stage");

  a_sink_ready_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output side is ready");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("item taken into a full stalled pipeline");

  a_item_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> $countones(valid_q) ==
             $countones($past(valid_q)) + int'($past(in_acc)) - int'($past(out_acc)))
    else $error("items lost or duplicated in pipeline");

endmodule

/* hw/rtl/hsl2rgb_levels.sv */
// hsl2rgb_levels: first two stages, forms the low and high levels from
// lightness and saturation and the three wrapped hues; depends on hsl2rgb_pkg
`timescale 1ns / 1ps

module hsl2rgb_levels
  import hsl2rgb_pkg::*;
(
  input  logic        clk_i,
  input  pipe_ctrl_t  pipe_i,
  input  logic [15:0] hue_i,
  input  logic [15:0] sat_i,
  input  logic [15:0] light_i,
  output logic [15:0] hue_r_o,
  output logic [15:0] hue_g_o,
  output logic [15:0] hue_b_o,
  output logic [15:0] lo_o,
  output logic [15:0] hi_o,
  output logic [15:0] diff_o
);

  // stage 1: level product and hue wrap
  logic        dark_d;
  logic [16:0] mul_b_d;
  logic [32:0] prod_d;
  logic [16:0] hr_sum;
  logic [15:0] hr_d, hb_d;

  always_comb begin
    dark_d  = !light_i[15];
    mul_b_d = dark_d ? (17'(sat_i) + 17'(FRAC_ONE)) : 17'(sat_i);
    prod_d  = 33'(light_i) * 33'(mul_b_d);
    hr_sum  = 17'(hue_i) + 17'(FRAC_THIRD);
    hr_d    = (hr_sum > 17'(FRAC_ONE)) ? 16'(hr_sum - 17'(FRAC_ONE)) : hr_sum[15:0];
    hb_d    = (hue_i >= FRAC_THIRD) ? (hue_i - FRAC_THIRD)
                                    : (hue_i + (FRAC_ONE - FRAC_THIRD));
  end

  logic [32:0] prod_q;
  logic [15:0] light_q, sat_q;
  logic        dark_q;
  logic [15:0] hr1_q, hg1_q, hb1_q;

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[STG_PROD]) begin
      prod_q  <= prod_d;
      light_q <= light_i;
      sat_q   <= sat_i;
      dark_q  <= dark_d;
      hr1_q   <= hr_d;
      hg1_q   <= hue_i;
      hb1_q   <= hb_d;
    end
  end

  // stage 2: divide, clamp and difference
  logic [17:0] quo;
  logic [18:0] hi_raw;
  logic [15:0] hi_d, lo_d, diff_d;
  logic [16:0] two_l;

  always_comb begin
    quo    = div_frac_one(34'(prod_q));
    hi_raw = dark_q ? 19'(quo) : (19'(light_q) + 19'(sat_q) - 19'(quo));
    hi_d   = (hi_raw > 19'(FRAC_ONE)) ? FRAC_ONE : hi_raw[15:0];
    two_l  = {light_q, 1'b0};
    lo_d   = (two_l < 17'(hi_d)) ? 16'd0 : 16'(two_l - 17'(hi_d));
    diff_d = (hi_d >= lo_d) ? (hi_d - lo_d) : 16'd0;
  end

  logic [15:0] hi_q, lo_q, diff_q;
  logic [15:0] hr2_q, hg2_q, hb2_q;

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[STG_LEVEL]) begin
      hi_q   <= hi_d;
      lo_q   <= lo_d;
      diff_q <= diff_d;
      hr2_q  <= hr1_q;
      hg2_q  <= hg1_q;
      hb2_q  <= hb1_q;
    end
  end

  assign hue_r_o = hr2_q;
  assign hue_g_o = hg2_q;
  assign hue_b_o = hb2_q;
  assign lo_o    = lo_q;
  assign hi_o    = hi_q;
  assign diff_o  = diff_q;

endmodule

/* hw/rtl/hsl2rgb_chan.sv */
// hsl2rgb_chan: stages three to six for one color channel, hue function
// and scaling to the output range; depends on hsl2rgb_pkg
`timescale 1ns / 1ps

module hsl2rgb_chan
  import hsl2rgb_pkg::*;
#(
  parameter int OUT_BITS = 8
) (
  input  logic                clk_i,
  input  pipe_ctrl_t          pipe_i,
  input  logic [15:0]         hue_i,
  input  logic [15:0]         lo_i,
  input  logic [15:0]         hi_i,
  input  logic [15:0]         diff_i,
  output logic [OUT_BITS-1:0] level_o
);

  localparam logic [15:0] OUT_MAX = 16'((1 << OUT_BITS) - 1);

  // stage 3: hue segment and ramp product
  logic [18:0] six_v;
  hue_seg_e    seg_d;
  logic [15:0] factor;
  logic [31:0] ramp_d;

  always_comb begin
    six_v = (19'(hue_i) << 2) + (19'(hue_i) << 1);
    priority if (six_v < 19'(FRAC_ONE)) begin
      seg_d = SEG_RISE;
    end else if (hue_i < HALF_LIMIT) begin
      seg_d = SEG_HIGH;
    end else if (hue_i < FALL_LIMIT) begin
      seg_d = SEG_FALL;
    end else begin
      seg_d = SEG_LOW;
    end
    unique case (seg_d)
      SEG_RISE: factor = six_v[15:0];
      SEG_FALL: factor = 16'(FALL_BASE - six_v);
      default:  factor = 16'd0;
    endcase
    ramp_d = 32'(diff_i) * 32'(factor);
  end

  logic [31:0] ramp_q;
  logic [15:0] lo3_q, hi3_q;
  hue_seg_e    seg_q;

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[STG_HMUL]) begin
      ramp_q <= ramp_d;
      lo3_q  <= lo_i;
      hi3_q  <= hi_i;
      seg_q  <= seg_d;
    end
  end

  // stage 4: level on the hue curve
  logic [17:0] ramp_quo;
  logic [18:0] ramp_sum;
  logic [15:0] level_d;

  always_comb begin
    ramp_quo = div_frac_one(34'(ramp_q));
    ramp_sum = 19'(lo3_q) + 19'(ramp_quo);
    unique case (seg_q)
      SEG_RISE, SEG_FALL:
        level_d = (ramp_sum > 19'(FRAC_ONE)) ? FRAC_ONE : ramp_sum[15:0];
      SEG_HIGH: level_d = hi3_q;
      SEG_LOW:  level_d = lo3_q;
      default:  level_d = lo3_q;
    endcase
  end

  logic [15:0] level_q;

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[STG_HMIX]) begin
      level_q <= level_d;
    end
  end

  // stage 5: scale product
  logic [31:0] scale_q;

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[STG_SMUL]) begin
      scale_q <= 32'(level_q) * 32'(OUT_MAX);
    end
  end

  // stage 6: divide and clamp into the output register
  logic [17:0]         scale_quo;
  logic [OUT_BITS-1:0] out_d;
  logic [OUT_BITS-1:0] out_q;

  always_comb begin
    scale_quo = div_frac_one(34'(scale_q));
    out_d     = (scale_quo > 18'(OUT_MAX)) ? OUT_MAX[OUT_BITS-1:0]
                                           : scale_quo[OUT_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[STG_OUT]) begin
      out_q <= out_d;
    end
  end

  assign level_o = out_q;

endmodule

/* test/hsl_to_rgb_converter_test.sv */
// hsl_to_rgb_converter_test: checks the hsl to rgb converter against a
// bit-exact predictor with random gaps on both sides and one long output stall
// depends on hsl2rgb_pkg, hsl2rgb_if and hsl_to_rgb_converter
`timescale 1ns / 1ps

module hsl_to_rgb_converter_test;

  localparam int OUT_BITS = 8;
  localparam longint unsigned UNITY = 65535;
  localparam longint unsigned THIRD = 21845;
  localparam longint unsigned CHAN_TOP = (64'd1 << OUT_BITS) - 1;
  localparam int RANDOM_ITEMS = 750;
  localparam int STALL_AT = 200;
  localparam int STALL_CYCLES = 80;
  localparam int CALM_FROM = 400;
  localparam int CALM_TO = 560;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [15:0] lightness;
  } hsl_item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] red;
    logic [OUT_BITS-1:0] green;
    logic [OUT_BITS-1:0] blue;
  } rgb_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hsl2rgb_hsl_if hsl ();
  hsl2rgb_rgb_if #(.OUT_BITS(OUT_BITS)) rgb ();

  hsl_to_rgb_converter #(
    .OUT_BITS(OUT_BITS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .hsl_i (hsl),
    .rgb_o (rgb)
  );

  hsl_item_t pending_hsl[$];
  rgb_item_t expected_rgb[$];

  int mismatch_count = 0;
  int taken_count = 0;
  int result_count = 0;
  int grey_count = 0;
  int directed_count = 0;
  int input_stall_cycles = 0;
  int stall_left;
  bit stall_done;

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned ramp_level(longint unsigned lo, longint unsigned hi,
                                                 longint unsigned v);
    longint unsigned span;
    longint unsigned r;
    span = (hi >= lo) ? hi - lo : 0;
    if (6 * v < UNITY) begin
      r = lo + (span * (6 * v)) / UNITY;
    end else if (2 * v < UNITY) begin
      r = hi;
    end else if (3 * v < 2 * UNITY) begin
      r = lo + (span * (4 * UNITY - 6 * v)) / UNITY;
    end else begin
      r = lo;
    end
    if (r > UNITY) begin
      r = UNITY;
    end
    return r;
  endfunction

  function automatic logic [OUT_BITS-1:0] scale_level(longint unsigned level);
    longint unsigned v;
    v = (level * CHAN_TOP) / UNITY;
    if (v > CHAN_TOP) begin
      v = CHAN_TOP;
    end
    return v[OUT_BITS-1:0];
  endfunction

  function automatic rgb_item_t convert_hsl(hsl_item_t px);
    longint unsigned h;
    longint unsigned s;
    longint unsigned l;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned vr;
    longint unsigned vb;
    rgb_item_t res;
    h = px.hue;
    s = px.saturation;
    l = px.lightness;
    if (s == 0) begin
      res.red = scale_level(l);
      res.green = res.red;
      res.blue = res.red;
    end else begin
      if (2 * l < UNITY) begin
        hi = (l * (UNITY + s)) / UNITY;
      end else begin
        hi = l + s - (s * l) / UNITY;
      end
      if (hi > UNITY) begin
        hi = UNITY;
      end
      lo = (2 * l > hi) ? 2 * l - hi : 0;
      vr = h + THIRD;
      if (vr > UNITY) begin
        vr = vr - UNITY;
      end
      vb = (h >= THIRD) ? h - THIRD : h + UNITY - THIRD;
      res.red = scale_level(ramp_level(lo, hi, vr));
      res.green = scale_level(ramp_level(lo, hi, h));
      res.blue = scale_level(ramp_level(lo, hi, vb));
    end
    return res;
  endfunction

  function automatic bit take_gap();
    if (taken_count >= CALM_FROM && taken_count < CALM_TO) begin
      return 1'b0;
    end
    return $urandom_range(99) < 26;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at result %0d: %s got %0d want %0d", result_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_item(int h, int s, int l);
    hsl_item_t px;
    px.hue = h[15:0];
    px.saturation = s[15:0];
    px.lightness = l[15:0];
    if (px.saturation == 0) begin
      grey_count++;
    end
    pending_hsl.push_back(px);
  endtask

  function automatic int pick_field();
    int edges[6] = '{0, 1, 32767, 32768, 65534, 65535};
    if ($urandom_range(99) < 20) begin
      return edges[$urandom_range(5)];
    end
    return $urandom_range(65535);
  endfunction

  function automatic int pick_hue();
    int marks[13] = '{0, 10922, 10923, 21844, 21845, 21846, 32767, 32768,
                      43689, 43690, 43691, 65534, 65535};
    if ($urandom_range(99) < 25) begin
      return marks[$urandom_range(12)];
    end
    return $urandom_range(65535);
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsl.valid <= 1'b0;
      hsl.hue <= '0;
      hsl.saturation <= '0;
      hsl.lightness <= '0;
    end else if (!hsl.valid || hsl.ready) begin
      if (pending_hsl.size() != 0 && !take_gap()) begin
        hsl.valid <= 1'b1;
        {hsl.hue, hsl.saturation, hsl.lightness} <= pending_hsl.pop_front();
      end else begin
        hsl.valid <= 1'b0;
      end
    end
  end

  // long output hold-off, once
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && taken_count >= STALL_AT) begin
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rgb.ready <= 1'b0;
    end else begin
      rgb.ready <= (stall_left == 0) && !take_gap();
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rgb_item_t want;
    if (rst_ni) begin
      if (hsl.valid && hsl.ready) begin
        expected_rgb.push_back(convert_hsl(hsl_item_t'({hsl.hue, hsl.saturation,
                                                         hsl.lightness})));
        taken_count <= taken_count + 1;
      end
      if (hsl.valid && !hsl.ready) begin
        input_stall_cycles <= input_stall_cycles + 1;
      end
      if (rgb.valid && rgb.ready) begin
        if (expected_rgb.size() == 0) begin
          report_mismatch("unexpected item, red", int'(rgb.red), -1);
        end else begin
          want = expected_rgb.pop_front();
          if (rgb.red !== want.red) begin
            report_mismatch("red", int'(rgb.red), int'(want.red));
          end
          if (rgb.green !== want.green) begin
            report_mismatch("green", int'(rgb.green), int'(want.green));
          end
          if (rgb.blue !== want.blue) begin
            report_mismatch("blue", int'(rgb.blue), int'(want.blue));
          end
        end
        result_count <= result_count + 1;
      end
    end
  end

  initial begin
    int pick;

    // grey, extremes and segment boundaries
    add_item(0, 0, 0);
    add_item(0, 0, 65535);
    add_item(1234, 0, 32767);
    add_item(40000, 0, 32768);
    add_item(0, 65535, 32767);
    add_item(65535, 65535, 32768);
    add_item(21845, 65535, 32767);
    add_item(43690, 65535, 32767);
    add_item(43691, 65535, 32767);
    add_item(10922, 65535, 20000);
    add_item(10923, 65535, 20000);
    add_item(32767, 65535, 40000);
    add_item(32768, 65535, 40000);
    add_item(43689, 65535, 50000);
    add_item(21844, 65535, 50000);
    add_item(5000, 65535, 0);
    add_item(5000, 65535, 65535);
    add_item(50000, 1, 32767);
    add_item(30000, 30000, 10000);
    add_item(60000, 45000, 55000);
    directed_count = pending_hsl.size();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        add_item($urandom_range(65535), 0, pick_field());
      end else if (pick < 30) begin
        add_item(pick_hue(), pick_field(), pick_field());
      end else begin
        add_item($urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_hsl.size() != 0 || hsl.valid) @(negedge clk_i);
    while (expected_rgb.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("covered %0d items (%0d directed, %0d grey), %0d results checked",
             taken_count, directed_count, grey_count, result_count);
    $display("output held off %0d cycles once, input stalled in %0d cycles",
             STALL_CYCLES, input_stall_cycles);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout with %0d results outstanding", expected_rgb.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/hsl2rgb_pkg.sv
hw/rtl/hsl2rgb_if.sv
hw/rtl/hsl2rgb_ctrl.sv
hw/rtl/hsl2rgb_levels.sv
hw/rtl/hsl2rgb_chan.sv
hw/rtl/hsl_to_rgb_converter.sv
test/hsl_to_rgb_converter_test.sv
